>>> src/lcdns_pkg.sv
`timescale 1ns / 1ps

package lcdns_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int REG_WIDTH   = 16;
    localparam int STEP_WIDTH  = 5;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX  = {COUNT_WIDTH{1'b1}};
    localparam logic [STEP_WIDTH-1:0]  STEPS_DONE = 5'd13;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_CMD     = 2'd1,
        OP_DATA    = 2'd2,
        OP_RESTART = 2'd3
    } opcode_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_POWER_WAIT = 3'd0,
        REG_FIRST_GAP  = 3'd1,
        REG_LATER_GAP  = 3'd2,
        REG_HOLD       = 3'd3,
        REG_CLEAR_WAIT = 3'd4
    } reg_index_t;

    // init sequence step kinds
    typedef enum logic [2:0] {
        KIND_BYTE   = 3'd0,
        KIND_NIB    = 3'd1,
        KIND_WPOWER = 3'd2,
        KIND_WFIRST = 3'd3,
        KIND_WLATER = 3'd4,
        KIND_WCLEAR = 3'd5,
        KIND_NONE   = 3'd6
    } step_kind_t;

    // nibble transfer phases
    typedef enum logic [6:0] {
        PH_IDLE     = 7'b0000001,
        PH_HI_SETUP = 7'b0000010,
        PH_HI_PULSE = 7'b0000100,
        PH_HI_HOLD  = 7'b0001000,
        PH_LO_SETUP = 7'b0010000,
        PH_LO_PULSE = 7'b0100000,
        PH_LO_HOLD  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic       rs;
        logic       en;
        logic [3:0] nib;
    } pins_t;

    typedef struct packed {
        logic [STEP_WIDTH-1:0]  init_step;
        logic [COUNT_WIDTH-1:0] wait_count;
        phase_t                 phase;
        logic [7:0]             held_byte;
        logic                   held_rs;
        pins_t                  pins;
    } core_state_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0] power_wait_us;
        logic [REG_WIDTH-1:0] first_gap_us;
        logic [REG_WIDTH-1:0] later_gap_us;
        logic [REG_WIDTH-1:0] hold_us;
        logic [REG_WIDTH-1:0] clear_wait_us;
    } cfg_t;

    localparam core_state_t STATE_RESET = '{
        init_step:  '0,
        wait_count: '0,
        phase:      PH_IDLE,
        held_byte:  8'h00,
        held_rs:    1'b0,
        pins:       '0
    };

    function automatic step_kind_t step_kind(input logic [STEP_WIDTH-1:0] idx);
        step_kind_t k;
        begin
            unique case (idx)
                5'd0:    k = KIND_WPOWER;
                5'd1:    k = KIND_NIB;
                5'd2:    k = KIND_WFIRST;
                5'd3:    k = KIND_NIB;
                5'd4:    k = KIND_WLATER;
                5'd5:    k = KIND_NIB;
                5'd6:    k = KIND_WLATER;
                5'd7:    k = KIND_NIB;
                5'd8:    k = KIND_BYTE;
                5'd9:    k = KIND_BYTE;
                5'd10:   k = KIND_BYTE;
                5'd11:   k = KIND_WCLEAR;
                5'd12:   k = KIND_BYTE;
                default: k = KIND_NONE;
            endcase
            return k;
        end
    endfunction

    function automatic logic [7:0] step_val(input logic [STEP_WIDTH-1:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                5'd1, 5'd3, 5'd5: v = 8'h03;
                5'd7:             v = 8'h02;
                5'd8:             v = 8'h28;
                5'd9:             v = 8'h0c;
                5'd10:            v = 8'h01;
                5'd12:            v = 8'h06;
                default:          v = 8'h00;
            endcase
            return v;
        end
    endfunction

endpackage

>>> src/lcdns_cfg.sv
`timescale 1ns / 1ps

module lcdns_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lcdns_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [lcdns_pkg::REG_WIDTH-1:0]    cfg_data,
    output lcdns_pkg::cfg_t                    cfg
);

    lcdns_pkg::cfg_t cfg_reg;
    lcdns_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                lcdns_pkg::REG_POWER_WAIT: cfg_next.power_wait_us = cfg_data;
                lcdns_pkg::REG_FIRST_GAP:  cfg_next.first_gap_us  = cfg_data;
                lcdns_pkg::REG_LATER_GAP:  cfg_next.later_gap_us  = cfg_data;
                lcdns_pkg::REG_HOLD:       cfg_next.hold_us       = cfg_data;
                lcdns_pkg::REG_CLEAR_WAIT: cfg_next.clear_wait_us = cfg_data;
                default:                   cfg_next = cfg_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_wait_us <= 16'd50000;
            cfg_reg.first_gap_us  <= 16'd5000;
            cfg_reg.later_gap_us  <= 16'd1000;
            cfg_reg.hold_us       <= 16'd100;
            cfg_reg.clear_wait_us <= 16'd2000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> src/lcdns_step.sv
`timescale 1ns / 1ps

module lcdns_step
(
    input  lcdns_pkg::core_state_t  cur,
    input  lcdns_pkg::cfg_t         cfg,
    input  lcdns_pkg::opcode_t      opcode,
    input  logic [7:0]              byte_value,
    output lcdns_pkg::core_state_t  nxt,
    output logic                    accepted
);

    // start the step at idx: load a nibble or byte, zero the wait counter for a wait, or nothing once past the end
    function automatic lcdns_pkg::core_state_t launch(
        input lcdns_pkg::core_state_t     st,
        input logic [lcdns_pkg::STEP_WIDTH-1:0] idx
    );
        lcdns_pkg::core_state_t s;
        lcdns_pkg::step_kind_t  k;
        logic [7:0]             v;
        begin
            s = st;
            k = lcdns_pkg::step_kind(idx);
            v = lcdns_pkg::step_val(idx);
            s.init_step = idx;
            case (k)
                lcdns_pkg::KIND_NIB:
                begin
                    s.held_byte = v;
                    s.held_rs   = 1'b0;
                    s.pins      = '{rs: 1'b0, en: 1'b0, nib: v[3:0]};
                    s.phase     = lcdns_pkg::PH_LO_SETUP;
                end
                lcdns_pkg::KIND_BYTE:
                begin
                    s.held_byte = v;
                    s.held_rs   = 1'b0;
                    s.pins      = '{rs: 1'b0, en: 1'b0, nib: v[7:4]};
                    s.phase     = lcdns_pkg::PH_HI_SETUP;
                end
                lcdns_pkg::KIND_NONE: ; // sequence finished, nothing to load
                default:              s.wait_count = '0;
            endcase
            return s;
        end
    endfunction

    lcdns_pkg::step_kind_t                kind;
    logic                                 init_done;
    logic                                 idle;
    logic [lcdns_pkg::COUNT_WIDTH-1:0]    cnt_inc;
    logic [lcdns_pkg::REG_WIDTH-1:0]      target;
    logic                                 wait_hit;
    logic                                 in_hold;

    assign kind      = lcdns_pkg::step_kind(cur.init_step);
    assign init_done = (cur.init_step >= lcdns_pkg::STEPS_DONE);
    assign idle      = (cur.phase == lcdns_pkg::PH_IDLE);
    assign in_hold   = (cur.phase == lcdns_pkg::PH_HI_HOLD) ||
                       (cur.phase == lcdns_pkg::PH_LO_HOLD);

    // saturating microsecond counter shared by holds and init waits
    assign cnt_inc = (cur.wait_count != lcdns_pkg::CNT_MAX) ?
                     cur.wait_count + 1'b1 : cur.wait_count;

    always_comb
    begin
        if (in_hold)
        begin
            target = cfg.hold_us;
        end
        else
        begin
            case (kind)
                lcdns_pkg::KIND_WPOWER: target = cfg.power_wait_us;
                lcdns_pkg::KIND_WFIRST: target = cfg.first_gap_us;
                lcdns_pkg::KIND_WLATER: target = cfg.later_gap_us;
                default:                target = cfg.clear_wait_us;
            endcase
        end
    end

    // a target beyond the counter range ends once the counter tops out
    assign wait_hit = (cnt_inc >= target) || (cnt_inc == lcdns_pkg::CNT_MAX);

    always_comb
    begin
        nxt      = cur;
        accepted = 1'b0;
        unique case (opcode)
            lcdns_pkg::OP_TICK:
            begin
                unique case (cur.phase)
                    lcdns_pkg::PH_HI_SETUP:
                    begin
                        nxt.pins  = '{rs: cur.held_rs, en: 1'b1, nib: cur.held_byte[7:4]};
                        nxt.phase = lcdns_pkg::PH_HI_PULSE;
                    end
                    lcdns_pkg::PH_HI_PULSE:
                    begin
                        nxt.pins       = '{rs: cur.held_rs, en: 1'b0, nib: cur.held_byte[7:4]};
                        nxt.phase      = lcdns_pkg::PH_HI_HOLD;
                        nxt.wait_count = '0;
                    end
                    lcdns_pkg::PH_HI_HOLD:
                    begin
                        nxt.wait_count = cnt_inc;
                        if (wait_hit)
                        begin
                            nxt.pins  = '{rs: cur.held_rs, en: 1'b0, nib: cur.held_byte[3:0]};
                            nxt.phase = lcdns_pkg::PH_LO_SETUP;
                        end
                    end
                    lcdns_pkg::PH_LO_SETUP:
                    begin
                        nxt.pins  = '{rs: cur.held_rs, en: 1'b1, nib: cur.held_byte[3:0]};
                        nxt.phase = lcdns_pkg::PH_LO_PULSE;
                    end
                    lcdns_pkg::PH_LO_PULSE:
                    begin
                        nxt.pins       = '{rs: cur.held_rs, en: 1'b0, nib: cur.held_byte[3:0]};
                        nxt.phase      = lcdns_pkg::PH_LO_HOLD;
                        nxt.wait_count = '0;
                    end
                    lcdns_pkg::PH_LO_HOLD:
                    begin
                        nxt.wait_count = cnt_inc;
                        if (wait_hit)
                        begin
                            nxt.phase = lcdns_pkg::PH_IDLE;
                            if (!init_done)
                                nxt = launch(nxt, cur.init_step + 1'b1);
                        end
                    end
                    lcdns_pkg::PH_IDLE:
                    begin
                        if (!init_done)
                        begin
                            if ((kind == lcdns_pkg::KIND_NIB) ||
                                (kind == lcdns_pkg::KIND_BYTE))
                            begin
                                nxt = launch(cur, cur.init_step);
                            end
                            else
                            begin
                                nxt.wait_count = cnt_inc;
                                if (wait_hit)
                                    nxt = launch(nxt, cur.init_step + 1'b1);
                            end
                        end
                    end
                    default: nxt.phase = lcdns_pkg::PH_IDLE;
                endcase
            end
            lcdns_pkg::OP_RESTART:
            begin
                nxt      = lcdns_pkg::STATE_RESET;
                accepted = 1'b1;
            end
            default: // command or data write
            begin
                if (init_done && idle)
                begin
                    nxt.held_byte = byte_value;
                    nxt.held_rs   = (opcode == lcdns_pkg::OP_DATA);
                    nxt.pins      = '{rs: (opcode == lcdns_pkg::OP_DATA), en: 1'b0,
                                      nib: byte_value[7:4]};
                    nxt.phase     = lcdns_pkg::PH_HI_SETUP;
                    accepted      = 1'b1;
                end
            end
        endcase
    end

endmodule

>>> src/char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps

// Character LCD sequencer for a 4-bit HD44780-style bus.
// Input stream (s_*): one request per item. s_tdata[1:0] opcode (0 one-microsecond
//   tick, 1 command write, 2 data write, 3 restart init), s_tdata[9:2] byte_value.
// Output stream (m_*): one result per request, giving the line levels after the
//   request and a ready flag; a write that was refused shows accepted = 0.
// Config port: cfg_we writes cfg_data into register cfg_addr (0 power wait,
//   1 first gap, 2 later gap, 3 hold, 4 clear wait, all in microseconds); other
//   indices are ignored. Write only while no request is in flight.
// Timing: a request is taken when s_tready is high; its result sits in the output
//   register on the next cycle, and the block takes a request every cycle while
//   the receiver does not stall. The rate is set by the single state-update step
//   (counter increment and compare) between state and result registers.
// Reset clears the sequencer to the start of the power-up sequence, drives all
//   lines low and restores the register defaults; opcode 3 does the same but
//   keeps the registers. If the receiver stalls, the result is held and
//   s_tready drops until it is taken (s_tready = output empty or m_tready).

module char_lcd_nibble_sequencer
(
    input  logic                              clk,
    input  logic                              rst_n,
    // stream in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,  // opcode[1:0], byte_value[9:2]
    // stream out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,  // rs_line[0], enable_line[1],
                                                        // data_lines[5:2], ready_res[6],
                                                        // accepted[7]
    // configuration
    input  logic                              cfg_we,
    input  logic [lcdns_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [lcdns_pkg::REG_WIDTH-1:0]   cfg_data
);

    lcdns_pkg::cfg_t        cfg;
    lcdns_pkg::core_state_t state_reg;
    lcdns_pkg::core_state_t state_next;
    lcdns_pkg::opcode_t     opcode;
    logic                   accepted;
    logic                   take;
    logic                   ready_now;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_data_reg;

    lcdns_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cfg      (cfg)
    );

    assign opcode = lcdns_pkg::opcode_t'(s_tdata[1:0]);

    lcdns_step u_step
    (
        .cur        (state_reg),
        .cfg        (cfg),
        .opcode     (opcode),
        .byte_value (s_tdata[9:2]),
        .nxt        (state_next),
        .accepted   (accepted)
    );

    // the output register frees up in the same cycle it is drained
    assign s_tready = !out_valid_reg || m_tready;
    assign take     = s_tvalid && s_tready;

    assign ready_now = (state_next.init_step >= lcdns_pkg::STEPS_DONE) &&
                       (state_next.phase == lcdns_pkg::PH_IDLE);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcdns_pkg::STATE_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
                state_reg <= state_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= {accepted, ready_now, state_next.pins.nib,
                             state_next.pins.en, state_next.pins.rs};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> test/tb_char_lcd_nibble_sequencer.sv
`timescale 1ns / 1ps

module tb_char_lcd_nibble_sequencer;

    // result word, laid out as m_tdata: rs[0], en[1], nib[5:2], ready[6], acc[7]
    typedef struct packed {
        logic       acc;
        logic       ready;
        logic [3:0] nib;
        logic       en;
        logic       rs;
    } lcd_result_t;

    typedef struct {
        lcdns_pkg::opcode_t op;
        logic [7:0]         val;
        bit                 typed;   // want holds the result typed in by hand
        lcd_result_t        want;
        bit                 run_in;  // afterwards, tick on until the bus is ready
    } dir_row_t;

    localparam lcd_result_t RES_QUIET =
        '{acc: 1'b0, ready: 1'b0, nib: 4'h0, en: 1'b0, rs: 1'b0};
    localparam lcd_result_t RES_RESTARTED =
        '{acc: 1'b1, ready: 1'b0, nib: 4'h0, en: 1'b0, rs: 1'b0};

    localparam int DIR_ROWS      = 19;
    localparam int ZERO_CFG_ROW  = 4;    // registers go to zero before this row
    localparam int RAND_PHASES   = 4;
    localparam int RAND_ITEMS    = 50;   // per phase
    localparam int HOLD_OFF_LEN  = 80;   // cycles the sink holds off in one go
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_LIMIT   = 20000;
    localparam logic [lcdns_pkg::REG_WIDTH-1:0] REG_TOP = {lcdns_pkg::REG_WIDTH{1'b1}};

    logic                             clk;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [15:0]                      s_tdata  = '0;   // opcode[1:0], byte_value[9:2]
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [7:0]                       m_tdata;  // rs[0], en[1], nib[5:2], ready[6], acc[7]
    logic                             cfg_we   = 1'b0;
    logic [lcdns_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [lcdns_pkg::REG_WIDTH-1:0]  cfg_data = '0;

    char_lcd_nibble_sequencer u_top
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Line-level predictor: its own copy of sequencer state and registers
    // ------------------------------------------------------------------
    lcdns_pkg::step_kind_t init_kinds [lcdns_pkg::STEPS_DONE] = '{
        lcdns_pkg::KIND_WPOWER, lcdns_pkg::KIND_NIB, lcdns_pkg::KIND_WFIRST,
        lcdns_pkg::KIND_NIB, lcdns_pkg::KIND_WLATER, lcdns_pkg::KIND_NIB,
        lcdns_pkg::KIND_WLATER, lcdns_pkg::KIND_NIB, lcdns_pkg::KIND_BYTE,
        lcdns_pkg::KIND_BYTE, lcdns_pkg::KIND_BYTE, lcdns_pkg::KIND_WCLEAR,
        lcdns_pkg::KIND_BYTE
    };
    logic [7:0] init_bytes [lcdns_pkg::STEPS_DONE] = '{
        8'h00, 8'h03, 8'h00, 8'h03, 8'h00, 8'h03, 8'h00,
        8'h02, 8'h28, 8'h0c, 8'h01, 8'h00, 8'h06
    };

    lcdns_pkg::cfg_t                   lcd_cfg = '{
        power_wait_us: 16'd50000, first_gap_us: 16'd5000, later_gap_us: 16'd1000,
        hold_us: 16'd100, clear_wait_us: 16'd2000
    };
    int unsigned                       lcd_step  = 0;
    logic [lcdns_pkg::COUNT_WIDTH-1:0] lcd_wait  = '0;
    lcdns_pkg::phase_t                 lcd_phase = lcdns_pkg::PH_IDLE;
    logic [7:0]                        lcd_byte  = '0;
    logic                              lcd_rs    = 1'b0;
    lcdns_pkg::pins_t                  lcd_pins  = '0;

    lcd_result_t expected_lines [$];
    int          fails = 0;
    bit          quiet = 1'b0;        // no idling on either side
    bit          hold_off_req = 1'b0;

    function automatic void pins_set(logic rs, logic en, logic [3:0] nib);
        lcd_pins.rs  = rs;
        lcd_pins.en  = en;
        lcd_pins.nib = nib;
    endfunction

    function automatic bit lcd_ready();
        return (lcd_step >= lcdns_pkg::STEPS_DONE) && (lcd_phase == lcdns_pkg::PH_IDLE);
    endfunction

    // one microsecond of a wait; a target past the counter range stops at the top
    function automatic bit count_done(logic [lcdns_pkg::REG_WIDTH-1:0] target);
        logic [lcdns_pkg::COUNT_WIDTH-1:0] lim;
        lim = (target > lcdns_pkg::CNT_MAX) ? lcdns_pkg::CNT_MAX :
              lcdns_pkg::COUNT_WIDTH'(target);
        if (lcd_wait != lcdns_pkg::CNT_MAX)
            lcd_wait = lcd_wait + 1'b1;
        return lcd_wait >= lim;
    endfunction

    function automatic logic [lcdns_pkg::REG_WIDTH-1:0] gap_for(lcdns_pkg::step_kind_t k);
        case (k)
            lcdns_pkg::KIND_WPOWER: return lcd_cfg.power_wait_us;
            lcdns_pkg::KIND_WFIRST: return lcd_cfg.first_gap_us;
            lcdns_pkg::KIND_WLATER: return lcd_cfg.later_gap_us;
            default:                return lcd_cfg.clear_wait_us;
        endcase
    endfunction

    function automatic void seq_launch();
        if (lcd_step >= lcdns_pkg::STEPS_DONE)
            return;
        case (init_kinds[lcd_step])
            lcdns_pkg::KIND_NIB:
            begin
                // bare init nibble: only the low half goes out
                lcd_byte = init_bytes[lcd_step];
                lcd_rs   = 1'b0;
                pins_set(1'b0, 1'b0, lcd_byte[3:0]);
                lcd_phase = lcdns_pkg::PH_LO_SETUP;
            end
            lcdns_pkg::KIND_BYTE:
            begin
                lcd_byte = init_bytes[lcd_step];
                lcd_rs   = 1'b0;
                pins_set(1'b0, 1'b0, lcd_byte[7:4]);
                lcd_phase = lcdns_pkg::PH_HI_SETUP;
            end
            default: lcd_wait = '0;
        endcase
    endfunction

    function automatic void seq_advance();
        if (lcd_step < lcdns_pkg::STEPS_DONE)
        begin
            lcd_step++;
            seq_launch();
        end
    endfunction

    function automatic void tick_advance();
        lcdns_pkg::step_kind_t k;
        case (lcd_phase)
            lcdns_pkg::PH_HI_SETUP:
            begin
                pins_set(lcd_rs, 1'b1, lcd_byte[7:4]);
                lcd_phase = lcdns_pkg::PH_HI_PULSE;
            end
            lcdns_pkg::PH_HI_PULSE:
            begin
                pins_set(lcd_rs, 1'b0, lcd_byte[7:4]);
                lcd_phase = lcdns_pkg::PH_HI_HOLD;
                lcd_wait  = '0;
            end
            lcdns_pkg::PH_HI_HOLD:
                if (count_done(lcd_cfg.hold_us))
                begin
                    pins_set(lcd_rs, 1'b0, lcd_byte[3:0]);
                    lcd_phase = lcdns_pkg::PH_LO_SETUP;
                end
            lcdns_pkg::PH_LO_SETUP:
            begin
                pins_set(lcd_rs, 1'b1, lcd_byte[3:0]);
                lcd_phase = lcdns_pkg::PH_LO_PULSE;
            end
            lcdns_pkg::PH_LO_PULSE:
            begin
                pins_set(lcd_rs, 1'b0, lcd_byte[3:0]);
                lcd_phase = lcdns_pkg::PH_LO_HOLD;
                lcd_wait  = '0;
            end
            lcdns_pkg::PH_LO_HOLD:
                if (count_done(lcd_cfg.hold_us))
                begin
                    lcd_phase = lcdns_pkg::PH_IDLE;
                    seq_advance();
                end
            default:
                if (lcd_step < lcdns_pkg::STEPS_DONE)
                begin
                    k = init_kinds[lcd_step];
                    if (k == lcdns_pkg::KIND_NIB || k == lcdns_pkg::KIND_BYTE)
                        seq_launch();
                    else if (count_done(gap_for(k)))
                        seq_advance();
                end
        endcase
    endfunction

    function automatic void lcd_restart();
        lcd_step  = 0;
        lcd_wait  = '0;
        lcd_phase = lcdns_pkg::PH_IDLE;
        lcd_byte  = '0;
        lcd_rs    = 1'b0;
        lcd_pins  = '0;
    endfunction

    function automatic lcd_result_t lcd_apply(lcdns_pkg::opcode_t op, logic [7:0] val);
        lcd_result_t r;
        r.acc = 1'b0;
        case (op)
            lcdns_pkg::OP_TICK: tick_advance();
            lcdns_pkg::OP_RESTART:
            begin
                lcd_restart();
                r.acc = 1'b1;
            end
            default:
                // writes only get in when init is over and the bus is idle
                if (lcd_ready())
                begin
                    lcd_byte = val;
                    lcd_rs   = (op == lcdns_pkg::OP_DATA);
                    pins_set(lcd_rs, 1'b0, val[7:4]);
                    lcd_phase = lcdns_pkg::PH_HI_SETUP;
                    r.acc    = 1'b1;
                end
        endcase
        r.rs    = lcd_pins.rs;
        r.en    = lcd_pins.en;
        r.nib   = lcd_pins.nib;
        r.ready = lcd_ready();
        return r;
    endfunction

    function automatic void cfg_apply(logic [lcdns_pkg::CFG_ADDR_W-1:0] idx,
                                      logic [lcdns_pkg::REG_WIDTH-1:0] v);
        case (idx)
            lcdns_pkg::REG_POWER_WAIT: lcd_cfg.power_wait_us = v;
            lcdns_pkg::REG_FIRST_GAP:  lcd_cfg.first_gap_us  = v;
            lcdns_pkg::REG_LATER_GAP:  lcd_cfg.later_gap_us  = v;
            lcdns_pkg::REG_HOLD:       lcd_cfg.hold_us       = v;
            lcdns_pkg::REG_CLEAR_WAIT: lcd_cfg.clear_wait_us = v;
            default: ;  // unknown index, dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, timeout
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink pacing: short random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------
    initial
    begin : sink_pace
        int n;
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                for (n = 0; n < HOLD_OFF_LEN; n++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every taken result against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fails++;
        end
    endfunction

    always @(posedge clk)
    begin : line_check
        lcd_result_t got;
        lcd_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = lcd_result_t'(m_tdata);
            if (expected_lines.size() == 0)
            begin
                $error("result 0x%02h with nothing expected", m_tdata);
                fails++;
            end
            else
            begin
                want = expected_lines.pop_front();
                check_field("rs_line",     want.rs,    got.rs);
                check_field("enable_line", want.en,    got.en);
                check_field("data_lines",  want.nib,   got.nib);
                check_field("ready_res",   want.ready, got.ready);
                check_field("accepted",    want.acc,   got.acc);
            end
        end
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    // Offers one request and waits for it to be taken; the prediction is made
    // at the edge that takes it. s_tvalid stays high for a following request unless a random pause drops it.
    task automatic send_request(lcdns_pkg::opcode_t op, logic [7:0] val, bit typed,
                                lcd_result_t want);
        lcd_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, val, op};
        do
            @(posedge clk);
        while (!s_tready);
        r = lcd_apply(op, val);
        expected_lines.push_back(typed ? want : r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic tick_until_ready();
        while (!lcd_ready())
            send_request(lcdns_pkg::OP_TICK, pick_byte(), 1'b0, RES_QUIET);
    endtask

    // stop offering and let every expected result come back
    task automatic drain_results();
        int guard;
        guard = 0;
        if (s_tvalid)
            s_tvalid <= 1'b0;
        while (expected_lines.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // all five registers, then one write to an index that does not exist
    task automatic set_config(logic [lcdns_pkg::REG_WIDTH-1:0] pw,
                              logic [lcdns_pkg::REG_WIDTH-1:0] fg,
                              logic [lcdns_pkg::REG_WIDTH-1:0] lg,
                              logic [lcdns_pkg::REG_WIDTH-1:0] hd,
                              logic [lcdns_pkg::REG_WIDTH-1:0] cw);
        logic [lcdns_pkg::REG_WIDTH-1:0]  vals [6];
        logic [lcdns_pkg::CFG_ADDR_W-1:0] idx  [6];
        int i;
        vals = '{pw, fg, lg, hd, cw, lcdns_pkg::REG_WIDTH'($urandom)};
        idx  = '{lcdns_pkg::REG_POWER_WAIT, lcdns_pkg::REG_FIRST_GAP,
                 lcdns_pkg::REG_LATER_GAP, lcdns_pkg::REG_HOLD, lcdns_pkg::REG_CLEAR_WAIT,
                 lcdns_pkg::CFG_ADDR_W'(lcdns_pkg::REG_CLEAR_WAIT + $urandom_range(1, 3))};
        drain_results();
        for (i = 0; i < 6; i++)
        begin
            cfg_we   <= 1'b1;
            cfg_addr <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            cfg_apply(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    dir_row_t dir_rows [DIR_ROWS];

    initial
    begin : stimulus
        int                 i;
        int                 ph;
        int                 r;
        lcdns_pkg::opcode_t op;
        dir_row_t           row;

        dir_rows = '{
            // register defaults: still inside the power-up wait
            '{lcdns_pkg::OP_TICK,    8'h00, 1'b1, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_CMD,     8'hff, 1'b1, RES_QUIET,     1'b0},  // busy write, refused
            '{lcdns_pkg::OP_DATA,    8'h00, 1'b1, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_RESTART, 8'ha5, 1'b1, RES_RESTARTED, 1'b0},
            // all waits zero from here: each lasts a single tick
            '{lcdns_pkg::OP_RESTART, 8'h00, 1'b1, RES_RESTARTED, 1'b0},
            '{lcdns_pkg::OP_TICK,    8'hff, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_CMD,     8'hff, 1'b0, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_DATA,    8'h5a, 1'b0, RES_QUIET,     1'b0},  // refused mid-transfer
            '{lcdns_pkg::OP_TICK,    8'h00, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_DATA,    8'h00, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_DATA,    8'hff, 1'b0, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_TICK,    8'h00, 1'b0, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_TICK,    8'h00, 1'b0, RES_QUIET,     1'b0},
            '{lcdns_pkg::OP_RESTART, 8'hc3, 1'b1, RES_RESTARTED, 1'b0},  // restart mid-transfer
            '{lcdns_pkg::OP_CMD,     8'h81, 1'b1, RES_QUIET,     1'b0},  // refused during init
            '{lcdns_pkg::OP_TICK,    8'h00, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_CMD,     8'h01, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_DATA,    8'h80, 1'b0, RES_QUIET,     1'b1},
            '{lcdns_pkg::OP_CMD,     8'h7f, 1'b0, RES_QUIET,     1'b1}
        };

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            if (i == ZERO_CFG_ROW)
                set_config('0, '0, '0, '0, '0);
            row = dir_rows[i];
            send_request(row.op, row.val, row.typed, row.want);
            if (row.run_in)
                tick_until_ready();
        end

        // random phases; the registers change between them, often mid-wait
        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            if (ph == 0)
                set_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
            else
                set_config(lcdns_pkg::REG_WIDTH'($urandom_range(0, 40)),
                           lcdns_pkg::REG_WIDTH'($urandom_range(0, 40)),
                           lcdns_pkg::REG_WIDTH'($urandom_range(0, 40)),
                           lcdns_pkg::REG_WIDTH'($urandom_range(0, 6)),
                           lcdns_pkg::REG_WIDTH'($urandom_range(0, 40)));
            for (i = 0; i < RAND_ITEMS; i++)
            begin
                if (ph == 1 && i == 40)
                    hold_off_req = 1'b1;   // sink backs off, requests pile up
                if (ph == 2 && i == 40)
                    drain_results();       // source pauses until all is back
                r = $urandom_range(0, 99);
                if (r < 2)
                    op = lcdns_pkg::OP_RESTART;
                else if (r < (lcd_ready() ? 45 : 7))
                    op = $urandom_range(0, 1) ? lcdns_pkg::OP_DATA : lcdns_pkg::OP_CMD;
                else
                    op = lcdns_pkg::OP_TICK;
                send_request(op, pick_byte(), 1'b0, RES_QUIET);
            end
        end

        // top-of-range power wait, cut short by a register write while it runs
        set_config(REG_TOP, 16'd2, 16'd1, 16'd1, 16'd3);
        send_request(lcdns_pkg::OP_RESTART, pick_byte(), 1'b0, RES_QUIET);
        repeat (6)
            send_request(lcdns_pkg::OP_TICK, pick_byte(), 1'b0, RES_QUIET);
        set_config(16'd3, 16'd2, 16'd1, 16'd1, 16'd3);
        tick_until_ready();
        send_request(lcdns_pkg::OP_DATA, pick_byte(), 1'b0, RES_QUIET);
        tick_until_ready();

        // last stretch with no idling: a long hold on one byte
        quiet = 1'b1;
        set_config('0, '0, '0, 16'd12, '0);
        send_request(lcdns_pkg::OP_CMD, pick_byte(), 1'b0, RES_QUIET);
        send_request(lcdns_pkg::OP_DATA, pick_byte(), 1'b0, RES_QUIET);
        tick_until_ready();
        send_request(lcdns_pkg::OP_DATA, pick_byte(), 1'b0, RES_QUIET);
        send_request(lcdns_pkg::OP_TICK, pick_byte(), 1'b0, RES_QUIET);

        drain_results();
        if (expected_lines.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_lines.size());
            fails++;
        end
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
src/lcdns_pkg.sv
src/lcdns_cfg.sv
src/lcdns_step.sv
src/char_lcd_nibble_sequencer.sv
test/tb_char_lcd_nibble_sequencer.sv
